// ===== rtl/core/ptc_pkg.sv =====
// shared types and constants of the pressure/temperature compensation pipeline
// no dependencies; imported by every module in rtl/core
package ptc_pkg;

    localparam int CFG_IDX_W     = 8;
    localparam int CAL_W         = 48;
    localparam int T_FINE_OFFSET = 128000;
    localparam int P_FULL_SCALE  = 1048576;
    localparam int DIV_SCALE     = 3125;
    localparam int DIV_STEPS     = 64;
    localparam int FRONT_STAGES  = 12;
    localparam int BACK_STAGES   = 7;
    localparam logic [63:0] P1_BIAS = 64'd1 << 47;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = CFG_IDX_W'(3);

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] temp_centideg;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } out_word_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic [31:0] temp;
        logic        pvalid;
    } side_t;

    typedef struct packed {
        logic [63:0]        dividend;
        logic signed [30:0] divisor;
        side_t              side;
    } front_word_t;

    typedef struct packed {
        logic [63:0] quot;
        side_t       side;
    } div_word_t;

endpackage

// ===== rtl/core/ptc_front.sv =====
// front stages: fine temperature, temperature output, dividend and divisor of the pressure
// depends on ptc_pkg
module ptc_front
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  in_word_t    in_word,
    input  cal_t        cal,
    output logic        out_valid,
    output front_word_t out_word
);

    typedef struct packed {
        logic signed [17:0] dt1;
        logic signed [16:0] d;
        logic [19:0]        adc_p;
    } s1_t;

    typedef struct packed {
        logic signed [33:0] ta;
        logic signed [33:0] dd;
        logic [19:0]        adc_p;
    } s2_t;

    typedef struct packed {
        logic signed [22:0] tas;
        logic signed [37:0] tb1;
        logic [19:0]        adc_p;
    } s3_t;

    typedef struct packed {
        logic signed [24:0] tf;
        logic [19:0]        adc_p;
    } s4_t;

    typedef struct packed {
        logic [31:0]        temp;
        logic signed [25:0] pa;
        logic [19:0]        adc_p;
    } s5_t;

    typedef struct packed {
        logic [31:0]        temp;
        logic signed [51:0] sq;
        logic signed [41:0] ap5;
        logic signed [41:0] ap2;
        logic [19:0]        adc_p;
    } s6_t;

    typedef struct packed {
        logic [31:0]        temp;
        logic signed [48:0] m6l;
        logic signed [35:0] m6h;
        logic signed [48:0] m3l;
        logic signed [35:0] m3h;
        logic signed [41:0] ap5;
        logic signed [41:0] ap2;
        logic [19:0]        adc_p;
    } s7_t;

    typedef struct packed {
        logic [31:0]        temp;
        logic [63:0]        b;
        logic [63:0]        a3;
        logic signed [41:0] ap2;
        logic [19:0]        adc_p;
    } s8_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [63:0] b;
        logic [63:0] av;
        logic [19:0] adc_p;
    } s9_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [47:0] pl;
        logic [31:0] ph;
        logic [63:0] pd;
    } s10_t;

    typedef struct packed {
        logic [31:0]        temp;
        logic signed [30:0] divisor;
        logic [43:0]        dl;
        logic [31:0]        dh;
    } s11_t;

    s1_t  s1_reg,  s1_next;
    s2_t  s2_reg,  s2_next;
    s3_t  s3_reg,  s3_next;
    s4_t  s4_reg,  s4_next;
    s5_t  s5_reg,  s5_next;
    s6_t  s6_reg,  s6_next;
    s7_t  s7_reg,  s7_next;
    s8_t  s8_reg,  s8_next;
    s9_t  s9_reg,  s9_next;
    s10_t s10_reg, s10_next;
    s11_t s11_reg, s11_next;
    front_word_t s12_reg, s12_next;
    logic [FRONT_STAGES-1:0] vld_reg, vld_next;

    always_comb
    begin
        s1_next.dt1 = $signed({1'b0, in_word.raw_temperature[19:3]})
                    - $signed({1'b0, cal.t1, 1'b0});
        s1_next.d   = $signed({1'b0, in_word.raw_temperature[19:4]})
                    - $signed({1'b0, cal.t1});
        s1_next.adc_p = in_word.raw_pressure;
    end

    always_comb
    begin
        s2_next.ta    = s1_reg.dt1 * $signed(cal.t2);
        s2_next.dd    = s1_reg.d * s1_reg.d;
        s2_next.adc_p = s1_reg.adc_p;
    end

    always_comb
    begin
        s3_next.tas   = s2_reg.ta[33:11];
        s3_next.tb1   = $signed(s2_reg.dd[33:12]) * $signed(cal.t3);
        s3_next.adc_p = s2_reg.adc_p;
    end

    always_comb
    begin
        s4_next.tf    = 25'(s3_reg.tas) + 25'($signed(s3_reg.tb1[37:14]));
        s4_next.adc_p = s3_reg.adc_p;
    end

    always_comb
    begin
        logic signed [27:0] t28;
        t28 = (28'(s4_reg.tf) <<< 2) + 28'(s4_reg.tf) + 28'sd128;
        s5_next.temp  = 32'($signed(t28[27:8]));
        s5_next.pa    = 26'(s4_reg.tf) - 26'(T_FINE_OFFSET);
        s5_next.adc_p = s4_reg.adc_p;
    end

    always_comb
    begin
        s6_next.temp  = s5_reg.temp;
        s6_next.sq    = s5_reg.pa * s5_reg.pa;
        s6_next.ap5   = s5_reg.pa * $signed(cal.p5);
        s6_next.ap2   = s5_reg.pa * $signed(cal.p2);
        s6_next.adc_p = s5_reg.adc_p;
    end

    // square split in two halves so each product stays narrow
    always_comb
    begin
        s7_next.temp  = s6_reg.temp;
        s7_next.m6l   = $signed({1'b0, s6_reg.sq[31:0]}) * $signed(cal.p6);
        s7_next.m6h   = $signed({1'b0, s6_reg.sq[50:32]}) * $signed(cal.p6);
        s7_next.m3l   = $signed({1'b0, s6_reg.sq[31:0]}) * $signed(cal.p3);
        s7_next.m3h   = $signed({1'b0, s6_reg.sq[50:32]}) * $signed(cal.p3);
        s7_next.ap5   = s6_reg.ap5;
        s7_next.ap2   = s6_reg.ap2;
        s7_next.adc_p = s6_reg.adc_p;
    end

    always_comb
    begin
        s8_next.temp  = s7_reg.temp;
        s8_next.b     = 64'(s7_reg.m6l) + {s7_reg.m6h[31:0], 32'b0}
                      + (64'(s7_reg.ap5) << 17) + (64'($signed(cal.p4)) << 35);
        s8_next.a3    = 64'(s7_reg.m3l) + {s7_reg.m3h[31:0], 32'b0};
        s8_next.ap2   = s7_reg.ap2;
        s8_next.adc_p = s7_reg.adc_p;
    end

    always_comb
    begin
        s9_next.temp  = s8_reg.temp;
        s9_next.b     = s8_reg.b;
        s9_next.av    = {{8{s8_reg.a3[63]}}, s8_reg.a3[63:8]}
                      + (64'(s8_reg.ap2) << 12) + P1_BIAS;
        s9_next.adc_p = s8_reg.adc_p;
    end

    always_comb
    begin
        logic [20:0] pm;
        pm = 21'(P_FULL_SCALE) - {1'b0, s9_reg.adc_p};
        s10_next.temp = s9_reg.temp;
        s10_next.pl   = s9_reg.av[31:0] * cal.p1;
        s10_next.ph   = s9_reg.av[63:32] * {16'b0, cal.p1};
        s10_next.pd   = (64'(pm) << 31) - s9_reg.b;
    end

    always_comb
    begin
        logic [63:0] prod;
        prod = 64'(s10_reg.pl) + {s10_reg.ph, 32'b0};
        s11_next.temp    = s10_reg.temp;
        s11_next.divisor = prod[63:33];
        s11_next.dl      = s10_reg.pd[31:0] * 12'(DIV_SCALE);
        s11_next.dh      = s10_reg.pd[63:32] * 32'(DIV_SCALE);
    end

    always_comb
    begin
        s12_next.dividend    = 64'(s11_reg.dl) + {s11_reg.dh, 32'b0};
        s12_next.divisor     = s11_reg.divisor;
        s12_next.side.temp   = s11_reg.temp;
        s12_next.side.pvalid = (s11_reg.divisor != '0);
    end

    assign vld_next = {vld_reg[FRONT_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            s9_reg  <= s9_next;
            s10_reg <= s10_next;
            s11_reg <= s11_next;
            s12_reg <= s12_next;
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_word  = s12_reg;

endmodule

// ===== rtl/core/ptc_div.sv =====
// pipelined signed 64-bit by 31-bit divider, one quotient bit per stage, truncating
// depends on ptc_pkg
module ptc_div
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  front_word_t in_word,
    output logic        out_valid,
    output div_word_t   out_word
);

    typedef struct packed {
        logic [63:0] work;
        logic [30:0] rem;
        logic [30:0] dmag;
        logic        neg;
        side_t       side;
    } dstage_t;

    dstage_t   dst_reg  [0:DIV_STEPS];
    dstage_t   dst_next [0:DIV_STEPS];
    div_word_t fix_reg, fix_next;
    logic [DIV_STEPS+1:0] vld_reg, vld_next;

    always_comb
    begin
        dst_next[0].neg  = in_word.dividend[63] ^ in_word.divisor[30];
        dst_next[0].work = in_word.dividend[63] ? (64'd0 - in_word.dividend)
                                                : in_word.dividend;
        dst_next[0].dmag = in_word.divisor[30] ? 31'(-in_word.divisor)
                                               : 31'(in_word.divisor);
        dst_next[0].rem  = '0;
        dst_next[0].side = in_word.side;
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        always_comb
        begin
            logic [31:0] trial;
            trial = {dst_reg[k].rem, dst_reg[k].work[63]};
            dst_next[k+1] = dst_reg[k];
            if (trial >= {1'b0, dst_reg[k].dmag})
            begin
                dst_next[k+1].rem  = 31'(trial - {1'b0, dst_reg[k].dmag});
                dst_next[k+1].work = {dst_reg[k].work[62:0], 1'b1};
            end
            else
            begin
                dst_next[k+1].rem  = trial[30:0];
                dst_next[k+1].work = {dst_reg[k].work[62:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        fix_next.quot = dst_reg[DIV_STEPS].neg ? (64'd0 - dst_reg[DIV_STEPS].work)
                                               : dst_reg[DIV_STEPS].work;
        fix_next.side = dst_reg[DIV_STEPS].side;
    end

    assign vld_next = {vld_reg[DIV_STEPS:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dst_reg[i] <= dst_next[i];
            end
            fix_reg <= fix_next;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS+1];
    assign out_word  = fix_reg;

endmodule

// ===== rtl/core/ptc_back.sv =====
// back stages: second-order pressure correction, offset, saturation and result register
// depends on ptc_pkg
module ptc_back
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_word_t in_word,
    input  cal_t      cal,
    output logic      out_valid,
    output out_word_t out_word
);

    typedef struct packed {
        logic [63:0]        q;
        logic [63:0]        ssll;
        logic [31:0]        sshl;
        logic signed [48:0] p8l;
        logic [31:0]        p8h;
        side_t              side;
    } b1_t;

    typedef struct packed {
        logic [63:0] q;
        logic [63:0] ss;
        logic [63:0] b8;
        side_t       side;
    } b2_t;

    typedef struct packed {
        logic [63:0]        q;
        logic [63:0]        b8;
        logic signed [48:0] m9l;
        logic [31:0]        m9h;
        side_t              side;
    } b3_t;

    typedef struct packed {
        logic [63:0] q;
        logic [63:0] b8;
        logic [63:0] a9;
        side_t       side;
    } b4_t;

    typedef struct packed {
        logic [63:0] sum;
        side_t       side;
    } b5_t;

    typedef struct packed {
        logic [63:0] p;
        side_t       side;
    } b6_t;

    b1_t b1_reg, b1_next;
    b2_t b2_reg, b2_next;
    b3_t b3_reg, b3_next;
    b4_t b4_reg, b4_next;
    b5_t b5_reg, b5_next;
    b6_t b6_reg, b6_next;
    out_word_t res_reg, res_next;
    logic [BACK_STAGES-1:0] vld_reg, vld_next;

    always_comb
    begin
        logic [63:0] s;
        s = {{13{in_word.quot[63]}}, in_word.quot[63:13]};
        b1_next.q    = in_word.quot;
        b1_next.ssll = s[31:0] * s[31:0];
        b1_next.sshl = s[63:32] * s[31:0];
        b1_next.p8l  = $signed({1'b0, in_word.quot[31:0]}) * $signed(cal.p8);
        b1_next.p8h  = in_word.quot[63:32] * 32'($signed(cal.p8));
        b1_next.side = in_word.side;
    end

    always_comb
    begin
        logic [63:0] p8q;
        p8q = 64'(b1_reg.p8l) + {b1_reg.p8h, 32'b0};
        b2_next.q    = b1_reg.q;
        b2_next.ss   = b1_reg.ssll + {b1_reg.sshl[30:0], 33'b0};
        b2_next.b8   = {{19{p8q[63]}}, p8q[63:19]};
        b2_next.side = b1_reg.side;
    end

    always_comb
    begin
        b3_next.q    = b2_reg.q;
        b3_next.b8   = b2_reg.b8;
        b3_next.m9l  = $signed({1'b0, b2_reg.ss[31:0]}) * $signed(cal.p9);
        b3_next.m9h  = b2_reg.ss[63:32] * 32'($signed(cal.p9));
        b3_next.side = b2_reg.side;
    end

    always_comb
    begin
        logic [63:0] m9;
        m9 = 64'(b3_reg.m9l) + {b3_reg.m9h, 32'b0};
        b4_next.q    = b3_reg.q;
        b4_next.b8   = b3_reg.b8;
        b4_next.a9   = {{25{m9[63]}}, m9[63:25]};
        b4_next.side = b3_reg.side;
    end

    always_comb
    begin
        b5_next.sum  = b4_reg.q + b4_reg.a9 + b4_reg.b8;
        b5_next.side = b4_reg.side;
    end

    always_comb
    begin
        b6_next.p    = {{8{b5_reg.sum[63]}}, b5_reg.sum[63:8]}
                     + (64'($signed(cal.p7)) << 4);
        b6_next.side = b5_reg.side;
    end

    // clamp to the unsigned 32-bit range, zero when the divisor was zero
    always_comb
    begin
        res_next.temp_centideg  = b6_reg.side.temp;
        res_next.pressure_valid = b6_reg.side.pvalid;
        priority if (!b6_reg.side.pvalid || b6_reg.p[63])
        begin
            res_next.pressure_q24_8 = '0;
        end
        else if (b6_reg.p[62:32] != '0)
        begin
            res_next.pressure_q24_8 = '1;
        end
        else
        begin
            res_next.pressure_q24_8 = b6_reg.p[31:0];
        end
    end

    assign vld_next = {vld_reg[BACK_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            b4_reg  <= b4_next;
            b5_reg  <= b5_next;
            b6_reg  <= b6_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[BACK_STAGES-1];
    assign out_word  = res_reg;

endmodule

// ===== rtl/core/pressure_temperature_compensation.sv =====
// top level: calibration registers and the front, divider and back pipeline sections
// depends on ptc_pkg, ptc_front, ptc_div, ptc_back
//
// usage
//   sample channel: sample_valid / sample_stall carry one word with a raw 20-bit
//   temperature and a raw 20-bit pressure reading
//   result channel: result_valid / result_stall carry one word with temperature in
//   0.01 degC, pressure in Pa as unsigned Q24.8 and a pressure valid flag
//   cfg channel: cfg_valid / cfg_ready with cfg_index 0..3 selecting the packed
//   calibration words; cfg_ready is always high, other indexes are ignored
// the pipeline has 12 front stages,
// 66 divider stages (one quotient bit per step) and 7 back stages
// throughput is one word per cycle unless stalled; every sample gives
// exactly one result; a stalled result holds the whole pipeline and
// sample_stall follows it in the same cycle; nothing is dropped or repeated
// reset clears all stage valid bits and the calibration registers to zero; the user
// must see that calibration is written only while the pipeline is empty (unchecked)
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  in_word_t             sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_word_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    logic [CAL_W-1:0] cal_temp_reg, cal_temp_next;
    logic [CAL_W-1:0] cal_plow_reg, cal_plow_next;
    logic [CAL_W-1:0] cal_pmid_reg, cal_pmid_next;
    logic [CAL_W-1:0] cal_phi_reg,  cal_phi_next;
    cal_t        cal;
    logic        en;
    logic        front_valid;
    front_word_t front_word;
    logic        div_valid;
    div_word_t   div_word;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cal_temp_next = cal_temp_reg;
        cal_plow_next = cal_plow_reg;
        cal_pmid_next = cal_pmid_reg;
        cal_phi_next  = cal_phi_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TEMP_CAL:  cal_temp_next = cfg_data;
                CFG_PRESS_LOW: cal_plow_next = cfg_data;
                CFG_PRESS_MID: cal_pmid_next = cfg_data;
                CFG_PRESS_HI:  cal_phi_next  = cfg_data;
                default:       cal_temp_next = cal_temp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg <= '0;
            cal_plow_reg <= '0;
            cal_pmid_reg <= '0;
            cal_phi_reg  <= '0;
        end
        else
        begin
            cal_temp_reg <= cal_temp_next;
            cal_plow_reg <= cal_plow_next;
            cal_pmid_reg <= cal_pmid_next;
            cal_phi_reg  <= cal_phi_next;
        end
    end

    assign cal.t1 = cal_temp_reg[15:0];
    assign cal.t2 = cal_temp_reg[31:16];
    assign cal.t3 = cal_temp_reg[47:32];
    assign cal.p1 = cal_plow_reg[15:0];
    assign cal.p2 = cal_plow_reg[31:16];
    assign cal.p3 = cal_plow_reg[47:32];
    assign cal.p4 = cal_pmid_reg[15:0];
    assign cal.p5 = cal_pmid_reg[31:16];
    assign cal.p6 = cal_pmid_reg[47:32];
    assign cal.p7 = cal_phi_reg[15:0];
    assign cal.p8 = cal_phi_reg[31:16];
    assign cal.p9 = cal_phi_reg[47:32];

    // whole pipeline advances unless the result word is held
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    ptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .in_word   (sample),
        .cal       (cal),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_word   (front_word),
        .out_valid (div_valid),
        .out_word  (div_word)
    );

    ptc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_word   (div_word),
        .cal       (cal),
        .out_valid (result_valid),
        .out_word  (result)
    );

endmodule
